// File: hdl/tswb_pkg.sv
package tswb_pkg;

	localparam int DEPTH = 64;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam logic REG_RETAIN_SPAN = 1'b0;
	localparam logic REG_WINDOW_UNLIM = 1'b1;

	typedef struct packed {
		logic [55:0] t_start;
		logic [55:0] t_end;
		logic [15:0] tag;
	} rec_t;

	typedef struct packed {
		logic        entry_valid;
		logic [15:0] out_tag;
		logic [55:0] out_start;
		logic [55:0] out_end;
		logic        last;
		logic        out_of_order;
		logic        overflow;
		logic [6:0]  stored_count;
		logic [55:0] oldest_start;
		logic [55:0] newest_end;
		logic [55:0] buffer_length;
	} res_t;

	// logical slot to ram address, ring starting at head
	function automatic logic [AW-1:0] phys(logic [AW-1:0] head, logic [CW-1:0] idx);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(idx);
		if (s >= (CW+1)'(DEPTH))
			s = s - (CW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] inc_ptr(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// File: hdl/tswb_if.sv
interface tswb_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [55:0] entry_start;
	logic [55:0] entry_end;
	logic [15:0] entry_tag;
	logic [39:0] query_span;
	modport source (output valid, kind, entry_start, entry_end, entry_tag, query_span,
		input ready);
	modport sink (input valid, kind, entry_start, entry_end, entry_tag, query_span,
		output ready);
endinterface

interface tswb_out_if;
	logic        valid;
	logic        ready;
	logic        entry_valid;
	logic [15:0] out_tag;
	logic [55:0] out_start;
	logic [55:0] out_end;
	logic        last;
	logic        out_of_order;
	logic        overflow;
	logic [6:0]  stored_count;
	logic [55:0] oldest_start;
	logic [55:0] newest_end;
	logic [55:0] buffer_length;
	modport source (output valid, entry_valid, out_tag, out_start, out_end, last,
		out_of_order, overflow, stored_count, oldest_start, newest_end, buffer_length,
		input ready);
	modport sink (input valid, entry_valid, out_tag, out_start, out_end, last,
		out_of_order, overflow, stored_count, oldest_start, newest_end, buffer_length,
		output ready);
endinterface

// File: hdl/tswb_ram.sv
module tswb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        waddr,
	input  logic [WIDTH-1:0]                wdata,
	input  logic                            re,
	input  logic [$clog2(DEPTH)-1:0]        raddr,
	output logic [WIDTH-1:0]                rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// File: hdl/time_sorted_window_buffer_top.sv
// channel  | role   | beat
// in_ch    | sink   | insert record or window query
// out_ch   | source | one result beat per insert, per selected record, or per empty query
// cfg      | write  | retain_span (index 0), window_unlimited (index 1)
// records live in one ram ring, accessed through its single read port
// insert: compares stored records from the newest back to place the record, then evicts old records
// query: walks records from the newest back, then emits the selected records; empty query gives one beat
// in_ch.ready is high only while idle; out_ch stalls hold the result and emit steps in place
// arst_n clears fill count, ring head and flags; ram contents need no clear
module time_sorted_window_buffer_top (
	input  logic          clk,
	input  logic          arst_n,
	tswb_in_if.sink       in_ch,
	tswb_out_if.source    out_ch,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [39:0]   cfg_data
);
	import tswb_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE      = 11'b00000000001,
		S_SHIFT_RD  = 11'b00000000010,
		S_SHIFT_CMP = 11'b00000000100,
		S_PUT       = 11'b00000001000,
		S_OLD_RD    = 11'b00000010000,
		S_OLD_CMP   = 11'b00000100000,
		S_RESULT    = 11'b00001000000,
		S_Q_RD      = 11'b00010000000,
		S_Q_CMP     = 11'b00100000000,
		S_E_RD      = 11'b01000000000,
		S_EMIT      = 11'b10000000000
	} state_t;

	state_t      state_q;
	logic [39:0] retain_span_q;
	logic        unlimited_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [55:0] newest_end_q;
	logic [55:0] oldest_start_q;
	rec_t        ins_q;
	logic [39:0] span_q;
	logic        ooo_q;
	logic        ovf_q;
	logic        out_valid_q;
	res_t        out_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	rec_t          ram_wdata, rd;

	tswb_ram #(.WIDTH($bits(rec_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	// accept and insert placement decisions
	logic          in_fire, out_free, out_load, full, append, fits, brk, evict;
	logic [AW-1:0] h1;
	logic [CW-1:0] c1;
	rec_t          in_rec;
	logic [55:0]   q_diff, e_diff;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_load = ((state_q == S_RESULT) || (state_q == S_EMIT)) && out_free;
	assign full = (count_q == CW'(DEPTH));
	assign h1 = full ? inc_ptr(head_q) : head_q;
	assign c1 = full ? count_q - 1'b1 : count_q;
	assign in_rec = '{t_start: in_ch.entry_start, t_end: in_ch.entry_end, tag: in_ch.entry_tag};
	assign append = (c1 == '0) || (in_ch.entry_end >= newest_end_q);
	assign fits = ins_q.t_end >= rd.t_end;
	assign q_diff = newest_end_q - rd.t_start;
	assign brk = (rd.t_start < newest_end_q) && (q_diff > {16'b0, span_q});
	assign e_diff = newest_end_q - rd.t_end;
	assign evict = !unlimited_q && (e_diff > {16'b0, retain_span_q});

	// ram port control
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = phys(head_q, idx_q + 1'b1);
		ram_wdata = ins_q;
		ram_re = 1'b0;
		ram_raddr = phys(head_q, idx_q);
		case (state_q)
			S_IDLE: begin
				ram_waddr = phys(h1, c1);
				ram_wdata = in_rec;
				ram_we = in_fire && (in_ch.kind == KIND_INSERT) && append;
			end
			S_SHIFT_CMP: begin
				ram_we = 1'b1;
				ram_wdata = fits ? ins_q : rd;
			end
			S_PUT: begin
				ram_we = 1'b1;
				ram_waddr = phys(head_q, '0);
			end
			S_SHIFT_RD, S_Q_RD, S_E_RD: ram_re = 1'b1;
			S_OLD_RD: begin
				ram_re = 1'b1;
				ram_raddr = phys(head_q, '0);
			end
			default: ;
		endcase
	end

	// summary fields seen in every result beat
	logic [55:0] st_os, st_ne, st_len;
	always_comb begin
		st_os = (count_q == '0) ? '0 : oldest_start_q;
		st_ne = (count_q == '0) ? '0 : newest_end_q;
		st_len = (st_ne > st_os) ? st_ne - st_os : '0;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retain_span_q <= '0;
			unlimited_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RETAIN_SPAN: retain_span_q <= cfg_data;
				REG_WINDOW_UNLIM: unlimited_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			ooo_q <= 1'b0;
			ovf_q <= 1'b0;
			newest_end_q <= '0;
			oldest_start_q <= '0;
			ins_q <= '0;
			span_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						ins_q <= in_rec;
						span_q <= in_ch.query_span;
						if (in_ch.kind == KIND_INSERT) begin
							head_q <= h1;
							count_q <= c1 + 1'b1;
							ovf_q <= full;
							ooo_q <= !append;
							if (append) begin
								newest_end_q <= in_ch.entry_end;
								state_q <= S_OLD_RD;
							end else begin
								idx_q <= c1 - 1'b1;
								state_q <= S_SHIFT_RD;
							end
						end else begin
							ooo_q <= 1'b0;
							ovf_q <= 1'b0;
							idx_q <= count_q - 1'b1;
							state_q <= (count_q == '0) ? S_RESULT : S_Q_RD;
						end
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_CMP;
				S_SHIFT_CMP: begin
					if (fits)
						state_q <= S_OLD_RD;
					else if (idx_q == '0)
						state_q <= S_PUT;
					else begin
						idx_q <= idx_q - 1'b1;
						state_q <= S_SHIFT_RD;
					end
				end
				S_PUT: state_q <= S_OLD_RD;
				S_OLD_RD: state_q <= S_OLD_CMP;
				S_OLD_CMP: begin
					oldest_start_q <= rd.t_start;
					if (evict) begin
						head_q <= inc_ptr(head_q);
						count_q <= count_q - 1'b1;
						state_q <= S_OLD_RD;
					end else
						state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				S_Q_RD: state_q <= S_Q_CMP;
				S_Q_CMP: begin
					if (brk || idx_q == '0)
						state_q <= S_E_RD;
					else begin
						idx_q <= idx_q - 1'b1;
						state_q <= S_Q_RD;
					end
				end
				S_E_RD: state_q <= S_EMIT;
				// read data of the selected record is held in the ram
				S_EMIT: begin
					if (out_free) begin
						if (idx_q == count_q - 1'b1)
							state_q <= S_IDLE;
						else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_E_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			if (state_q == S_EMIT)
				out_q <= '{entry_valid: 1'b1, out_tag: rd.tag, out_start: rd.t_start,
					out_end: rd.t_end, last: (idx_q == count_q - 1'b1), out_of_order: 1'b0,
					overflow: 1'b0, stored_count: 7'(count_q), oldest_start: st_os,
					newest_end: st_ne, buffer_length: st_len};
			else
				out_q <= '{entry_valid: 1'b0, out_tag: '0, out_start: '0, out_end: '0,
					last: 1'b1, out_of_order: ooo_q, overflow: ovf_q,
					stored_count: 7'(count_q), oldest_start: st_os,
					newest_end: st_ne, buffer_length: st_len};
		end else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.entry_valid = out_q.entry_valid;
	assign out_ch.out_tag = out_q.out_tag;
	assign out_ch.out_start = out_q.out_start;
	assign out_ch.out_end = out_q.out_end;
	assign out_ch.last = out_q.last;
	assign out_ch.out_of_order = out_q.out_of_order;
	assign out_ch.overflow = out_q.overflow;
	assign out_ch.stored_count = out_q.stored_count;
	assign out_ch.oldest_start = out_q.oldest_start;
	assign out_ch.newest_end = out_q.newest_end;
	assign out_ch.buffer_length = out_q.buffer_length;

	// checks on fill level, ready, eviction and the last flag
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("fill count above depth");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ch.ready) else $error("ready right after accept");
	a_evict_keeps_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OLD_CMP |-> count_q != '0) else $error("eviction emptied store");
	a_ins_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.entry_valid |-> out_q.last) else $error("lone beat not last");
endmodule
